// ===== rtl/core/alc_pkg.sv =====
// Shared constants for the average-linkage clustering core.
// Configuration register indexes, reset values and result field widths.
// No dependencies.
package alc_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_DIST_WIDTH = 32;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CUTOFF_W   = 32;
	localparam int REG_CNT_W  = 7;

	localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_CLUSTERS = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DISTANCE_CUTOFF = 2'd2;

	localparam logic [REG_CNT_W-1:0] RST_POINT_COUNT     = 7'd64;
	localparam logic [REG_CNT_W-1:0] RST_TARGET_CLUSTERS = 7'd1;
	localparam logic [CUTOFF_W-1:0]  RST_DISTANCE_CUTOFF = 32'hffff_ffff;

	localparam int OUT_IDX_W   = 6;
	localparam int OUT_CNT_W   = 7;
	localparam int OUT_TDATA_W = 24;

endpackage

// ===== rtl/core/alc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Used for every store of the clustering core. No dependencies.
module alc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/average_linkage_clustering_core.sv =====
// Top level of the average-linkage (UPGMA) clustering core.
// Uses alc_pkg and alc_ram for the distance, member, parent and label stores.
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------------------
//  s_*      | in  | tdata: distance_value; tlast: last_entry
//  m_*      | out | tdata: point_index, cluster_label, cluster_count; tlast: last_result
//  cfg_*    | in  | write: 0 point_count, 1 target_clusters, 2 distance_cutoff
//
// Load: one matrix item per cycle into the distance RAM.
// Each merge: a minimum search over all pairs through the distance RAM port,
// then for every live cluster x except the merged one: two reads, multiply,
// bit-serial divide and write back; every other x is skipped.
// Labels: per point the LP, LA, optional LB and OUT states, plus any wait on m_tready.
// Reset: no clearing pass; per-entry valid bits stand in for member and parent resets.
module average_linkage_clustering_core
	import alc_pkg::*;
#(
	parameter int MAX_POINTS = alc_pkg::DEF_MAX_POINTS,
	parameter int DIST_WIDTH = alc_pkg::DEF_DIST_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [DIST_WIDTH-1:0] distance_value, zero filled to bytes
	input  logic [((DIST_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// [5:0] point_index, [11:6] cluster_label, [18:12] cluster_count, rest zero
	output logic [alc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [alc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DW    = DIST_WIDTH;
	localparam int P     = MAX_POINTS;
	localparam int IW    = (P > 2) ? $clog2(P) : 1;
	localparam int CW    = $clog2(P + 1);
	localparam int SD    = P * (P - 1) / 2;
	localparam int AW    = (SD > 1) ? $clog2(SD) : 1;
	localparam int PW    = $clog2(SD + 1);
	localparam int TW    = 2 * CW + 1;
	localparam int NW    = DW + CW;
	localparam int DCW   = $clog2(NW + 1);
	localparam int CMPW  = (DW > CUTOFF_W) ? DW : CUTOFF_W;

	localparam logic [4:0] S_LOAD   = 5'd0;
	localparam logic [4:0] S_CHECK  = 5'd1;
	localparam logic [4:0] S_SCAN   = 5'd2;
	localparam logic [4:0] S_DRAIN  = 5'd3;
	localparam logic [4:0] S_DECIDE = 5'd4;
	localparam logic [4:0] S_MEMA   = 5'd5;
	localparam logic [4:0] S_MEMB   = 5'd6;
	localparam logic [4:0] S_UPD    = 5'd7;
	localparam logic [4:0] S_RDB    = 5'd8;
	localparam logic [4:0] S_MUL    = 5'd9;
	localparam logic [4:0] S_SUM    = 5'd10;
	localparam logic [4:0] S_DIV    = 5'd11;
	localparam logic [4:0] S_WR     = 5'd12;
	localparam logic [4:0] S_LP     = 5'd13;
	localparam logic [4:0] S_LA     = 5'd14;
	localparam logic [4:0] S_LB     = 5'd15;
	localparam logic [4:0] S_OUT    = 5'd16;

	function automatic logic [AW-1:0] tri_pos(input logic [IW-1:0] a, input logic [IW-1:0] b,
			input logic [CW-1:0] n);
		logic [TW-1:0] aa;
		logic [TW-1:0] t;
		begin
			aa = TW'(a);
			t = aa * TW'(n) - ((aa * (aa + 1'b1)) >> 1) + TW'(b) - aa - 1'b1;
			return t[AW-1:0];
		end
	endfunction

	// configuration
	logic [REG_CNT_W-1:0] point_count_q, target_q;
	logic [CUTOFF_W-1:0]  cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= RST_POINT_COUNT;
			target_q      <= RST_TARGET_CLUSTERS;
			cutoff_q      <= RST_DISTANCE_CUTOFF;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_POINT_COUNT:     point_count_q <= cfg_wdata[REG_CNT_W-1:0];
				CFG_TARGET_CLUSTERS: target_q      <= cfg_wdata[REG_CNT_W-1:0];
				CFG_DISTANCE_CUTOFF: cutoff_q      <= cfg_wdata[CUTOFF_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n_cfg;
	logic [PW-1:0] size_cfg;
	logic [REG_CNT_W-1:0] k_cfg;
	logic [DW-1:0] din;

	always_comb begin
		if (point_count_q < REG_CNT_W'(2)) n_cfg = CW'(2);
		else if (point_count_q > REG_CNT_W'(P)) n_cfg = CW'(P);
		else n_cfg = point_count_q[CW-1:0];
		size_cfg = PW'((TW'(n_cfg) * (TW'(n_cfg) - 1'b1)) >> 1);
		k_cfg = (target_q == '0) ? REG_CNT_W'(1) : target_q;
		for (int b = 0; b < DW; b++) begin
			din[b] = (b < CUTOFF_W) ? s_tdata[b] : 1'b0;
		end
	end

	// control state
	logic [4:0]           state_q;
	logic [PW-1:0]        pos_q;
	logic [CW-1:0]        n_q, live_cnt_q, x_q, lp_q, next_q;
	logic [REG_CNT_W-1:0] k_q;
	logic [P-1:0]         live_q, mv_q, pv_q;
	logic [IW-1:0]        si_q, sj_q, si_s1, sj_s1, bi_q, bj_q;
	logic [AW-1:0]        sp_q;
	logic                 scan_v_s1, found_q, mvalid_s1, pvalid_s1;
	logic [DW-1:0]        best_q, da_q;
	logic [CW-1:0]        ni_q, nj_q, nj_now;
	logic [NW-1:0]        pa_s, pb_s, num_q;
	logic [CW-1:0]        rem_q;
	logic [DCW-1:0]       dcnt_q;
	logic [CW:0]          div_s, rem2;
	logic                 div_ge;
	logic [IW-1:0]        lab_q, a_now;

	// RAM ports
	logic                 dwe;
	logic [AW-1:0]        dwaddr, draddr;
	logic [DW-1:0]        dwdata, drdata;
	logic                 mwe, pwe, lwe;
	logic [IW-1:0]        mraddr, praddr, lraddr, lwaddr, lwdata;
	logic [CW-1:0]        mrdata;
	logic [IW-1:0]        prdata, lrdata;
	logic [IW-1:0]        x_idx, lo_bi, hi_bi, lo_bj, hi_bj;
	logic                 in_acc, out_load, scan_last;

	assign s_tready = (state_q == S_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!m_tvalid || m_tready);
	assign x_idx    = x_q[IW-1:0];
	assign lo_bi    = (bi_q < x_idx) ? bi_q : x_idx;
	assign hi_bi    = (bi_q < x_idx) ? x_idx : bi_q;
	assign lo_bj    = (bj_q < x_idx) ? bj_q : x_idx;
	assign hi_bj    = (bj_q < x_idx) ? x_idx : bj_q;
	assign scan_last = (CW'(si_q) == n_q - CW'(2)) && (CW'(sj_q) == n_q - 1'b1);
	assign div_s    = (CW+1)'(ni_q) + (CW+1)'(nj_q);
	assign rem2     = {rem_q, num_q[NW-1]};
	assign div_ge   = (rem2 >= div_s);
	assign nj_now   = mvalid_s1 ? mrdata : CW'(1);
	assign a_now    = pvalid_s1 ? prdata : lp_q[IW-1:0];

	always_comb begin
		dwe    = 1'b0;
		dwaddr = pos_q[AW-1:0];
		dwdata = din;
		draddr = sp_q;
		if (state_q == S_LOAD) begin
			dwe = in_acc && (pos_q < size_cfg);
		end else if (state_q == S_WR) begin
			dwe    = 1'b1;
			dwaddr = tri_pos(lo_bi, hi_bi, n_q);
			dwdata = num_q[DW-1:0];
		end
		if (state_q == S_UPD) draddr = tri_pos(lo_bi, hi_bi, n_q);
		else if (state_q == S_RDB) draddr = tri_pos(lo_bj, hi_bj, n_q);
		mraddr = (state_q == S_DECIDE) ? bi_q : bj_q;
		mwe    = (state_q == S_MEMB);
		pwe    = (state_q == S_MEMB);
		praddr = lp_q[IW-1:0];
		lraddr = a_now;
		lwaddr = lp_q[IW-1:0];
		lwe    = 1'b0;
		lwdata = lrdata;
		if (state_q == S_LA && a_now == lp_q[IW-1:0]) begin
			lwe    = 1'b1;
			lwdata = next_q[IW-1:0];
		end else if (state_q == S_LB) begin
			lwe = 1'b1;
		end
	end

	alc_ram #(.WIDTH(DW), .DEPTH(SD)) u_dist (
		.clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata), .raddr(draddr), .rdata(drdata)
	);
	alc_ram #(.WIDTH(CW), .DEPTH(P)) u_member (
		.clk(clk), .we(mwe), .waddr(bi_q), .wdata(CW'(ni_q + nj_now)), .raddr(mraddr),
		.rdata(mrdata)
	);
	alc_ram #(.WIDTH(IW), .DEPTH(P)) u_parent (
		.clk(clk), .we(pwe), .waddr(bj_q), .wdata(bi_q), .raddr(praddr), .rdata(prdata)
	);
	alc_ram #(.WIDTH(IW), .DEPTH(P)) u_label (
		.clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr), .rdata(lrdata)
	);

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		mvalid_s1 <= mv_q[mraddr];
		pvalid_s1 <= pv_q[praddr];
		si_s1     <= si_q;
		sj_s1     <= sj_q;
		if (scan_v_s1 && (!found_q || drdata < best_q)) begin
			best_q <= drdata;
			bi_q   <= si_s1;
			bj_q   <= sj_s1;
		end
		if (state_q == S_MEMA) ni_q <= mvalid_s1 ? mrdata : CW'(1);
		if (state_q == S_MEMB) nj_q <= nj_now;
		if (state_q == S_RDB) da_q <= drdata;
		if (state_q == S_MUL) begin
			pa_s <= NW'(da_q) * NW'(ni_q);
			pb_s <= NW'(drdata) * NW'(nj_q);
		end
		if (state_q == S_SUM) begin
			num_q  <= pa_s + pb_s;
			rem_q  <= '0;
			dcnt_q <= DCW'(NW);
		end
		// restoring divide, one quotient bit per cycle shifted into num_q
		if (state_q == S_DIV) begin
			rem_q  <= div_ge ? CW'(rem2 - div_s) : rem2[CW-1:0];
			num_q  <= {num_q[NW-2:0], div_ge};
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (state_q == S_LA && a_now == lp_q[IW-1:0]) lab_q <= next_q[IW-1:0];
		if (state_q == S_LB) lab_q <= lrdata;
		if (out_load) begin
			m_tdata <= {(OUT_TDATA_W-OUT_CNT_W-2*OUT_IDX_W)'(0), OUT_CNT_W'(live_cnt_q),
				OUT_IDX_W'(lab_q), OUT_IDX_W'(lp_q)};
			m_tlast <= (lp_q == n_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			pos_q      <= '0;
			n_q        <= CW'(2);
			k_q        <= REG_CNT_W'(1);
			live_cnt_q <= CW'(P);
			live_q     <= '1;
			mv_q       <= '0;
			pv_q       <= '0;
			si_q       <= '0;
			sj_q       <= '0;
			sp_q       <= '0;
			scan_v_s1  <= 1'b0;
			found_q    <= 1'b0;
			x_q        <= '0;
			lp_q       <= '0;
			next_q     <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (state_q != S_SCAN) scan_v_s1 <= 1'b0;
			if (scan_v_s1) found_q <= 1'b1;
			if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (pos_q < size_cfg) pos_q <= pos_q + 1'b1;
						if (s_tlast) begin
							n_q        <= n_cfg;
							k_q        <= k_cfg;
							live_cnt_q <= n_cfg;
							state_q    <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					si_q    <= '0;
					sj_q    <= IW'(1);
					sp_q    <= '0;
					found_q <= 1'b0;
					if (REG_CNT_W'(live_cnt_q) <= k_q) begin
						lp_q    <= '0;
						next_q  <= '0;
						state_q <= S_LP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_v_s1 <= live_q[si_q] && live_q[sj_q];
					sp_q      <= sp_q + 1'b1;
					if (CW'(sj_q) == n_q - 1'b1) begin
						si_q <= si_q + 1'b1;
						sj_q <= si_q + IW'(2);
					end else begin
						sj_q <= sj_q + 1'b1;
					end
					if (scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (CMPW'(best_q) > CMPW'(cutoff_q)) begin
						lp_q    <= '0;
						next_q  <= '0;
						state_q <= S_LP;
					end else begin
						state_q <= S_MEMA;
					end
				end
				S_MEMA: state_q <= S_MEMB;
				S_MEMB: begin
					mv_q[bi_q]   <= 1'b1;
					pv_q[bj_q]   <= 1'b1;
					live_q[bj_q] <= 1'b0;
					live_cnt_q   <= live_cnt_q - 1'b1;
					x_q          <= '0;
					state_q      <= S_UPD;
				end
				S_UPD: begin
					if (x_q == n_q) begin
						state_q <= S_CHECK;
					end else if (x_idx == bi_q || !live_q[x_idx]) begin
						x_q <= x_q + 1'b1;
					end else begin
						state_q <= S_RDB;
					end
				end
				S_RDB: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_DIV;
				S_DIV: if (dcnt_q == DCW'(1)) state_q <= S_WR;
				S_WR: begin
					x_q     <= x_q + 1'b1;
					state_q <= S_UPD;
				end
				S_LP: state_q <= S_LA;
				S_LA: begin
					if (a_now == lp_q[IW-1:0]) begin
						next_q  <= next_q + 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LB;
					end
				end
				S_LB: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						m_tvalid <= 1'b1;
						if (lp_q == n_q - 1'b1) begin
							// batch done: restore member, parent and load state
							mv_q    <= '0;
							pv_q    <= '0;
							live_q  <= '1;
							pos_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							lp_q    <= lp_q + 1'b1;
							state_q <= S_LP;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_dist_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dwe |-> (state_q == S_LOAD || state_q == S_WR))
		else $error("distance write outside load or write-back");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_s != '0))
		else $error("zero divisor in average");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEMA) |-> (bi_q < bj_q))
		else $error("merge pair out of order");
	a_merge_kills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEMB) |=> !live_q[bj_q])
		else $error("merged cluster still live");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for average_linkage_clustering_core.
// Streams distance matrices, predicts every point label in a local UPGMA model and
// checks each output item against it. Depends on alc_pkg and the core RTL.
module tb;
	import alc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS  = 64;
	localparam int DEPTH = NPTS * (NPTS - 1) / 2;

	typedef struct packed {
		logic [5:0] point;
		logic [5:0] label;
		logic [6:0] count;
		logic       last;
	} label_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = CFG_POINT_COUNT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	average_linkage_clustering_core i_dut (.*);

	always #5 clk = ~clk;

	// local copy of the clustering state
	logic [6:0]  pc_reg = RST_POINT_COUNT;
	logic [6:0]  tgt_reg = RST_TARGET_CLUSTERS;
	logic [31:0] cut_reg = RST_DISTANCE_CUTOFF;
	logic [31:0] dist_mem [DEPTH];
	logic [6:0]  members [NPTS];
	logic [5:0]  parent [NPTS];
	int          load_pos = 0;
	int          live_cnt = NPTS;

	label_item_t label_q[$];
	int errors = 0;
	int words_sent = 0;
	int labels_seen = 0;
	int batches = 0;
	int burst_left = 0;
	int hold_cycles = 0;
	int ready_mode = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR t=%0t %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int eff_points();
		if (pc_reg < 2) return 2;
		if (pc_reg > NPTS) return NPTS;
		return pc_reg;
	endfunction

	function automatic int dist_pos(int a, int b, int n);
		int p;
		int t;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		p = a * n - a * (a + 1) / 2 + (b - a - 1);
		return (p < DEPTH) ? p : 0;
	endfunction

	function automatic void clear_batch();
		for (int k = 0; k < NPTS; k++) begin
			members[k] = 7'd1;
			parent[k] = k[5:0];
		end
		load_pos = 0;
	endfunction

	function automatic logic [31:0] weighted_mean(logic [31:0] da, int ma,
			logic [31:0] db, int mb);
		logic [63:0] s;
		s = 64'(ma) + 64'(mb);
		if (s == 0) return da;
		return 32'((64'(da) * 64'(ma) + 64'(db) * 64'(mb)) / s);
	endfunction

	function automatic void merge_clusters(int n);
		int k;
		int bi;
		int bj;
		int ni;
		int nj;
		bit found;
		bit done;
		logic [31:0] best;
		logic [31:0] d;
		k = (tgt_reg == 0) ? 1 : tgt_reg;
		live_cnt = n;
		done = 0;
		while (!done && live_cnt > k) begin
			found = 0; best = '0; bi = 0; bj = 0;
			for (int i = 0; i < n; i++) begin
				if (parent[i] != i) continue;
				for (int j = i + 1; j < n; j++) begin
					if (parent[j] != j) continue;
					d = dist_mem[dist_pos(i, j, n)];
					if (!found || d < best) begin
						found = 1; best = d; bi = i; bj = j;
					end
				end
			end
			if (!found || best > cut_reg) begin
				done = 1;
			end else begin
				ni = members[bi];
				nj = members[bj];
				members[bi] = 7'(ni + nj);
				parent[bj] = bi[5:0];
				for (int x = 0; x < n; x++) begin
					if (x == bi || parent[x] != x) continue;
					dist_mem[dist_pos(bi, x, n)] = weighted_mean(
						dist_mem[dist_pos(bi, x, n)], ni, dist_mem[dist_pos(bj, x, n)], nj);
				end
				live_cnt--;
			end
		end
	endfunction

	function automatic void predict_word(logic [31:0] data, logic last);
		int n;
		int nxt;
		int a;
		int lab [NPTS];
		label_item_t it;
		n = eff_points();
		if (load_pos < n * (n - 1) / 2) begin
			dist_mem[load_pos] = data;
			load_pos++;
		end
		if (!last) return;
		merge_clusters(n);
		nxt = 0;
		for (int p = 0; p < n; p++) begin
			a = parent[p];
			if (a >= n) a = p;
			if (a == p) lab[p] = nxt++;
			else lab[p] = (a < p) ? lab[a] : 0;
			it.point = p[5:0];
			it.label = lab[p][5:0];
			it.count = live_cnt[6:0];
			it.last = (p == n - 1);
			label_q.push_back(it);
		end
		clear_batch();
		batches++;
	endfunction

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
		logic [31:0] junk;
		junk = $urandom();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		// upper bits of the short registers carry junk that must be dropped
		if (addr == CFG_DISTANCE_CUTOFF) cfg_wdata <= value;
		else cfg_wdata <= {junk[31:7], value[6:0]};
		@(negedge clk);
		cfg_we <= 1'b0;
		case (addr)
			CFG_POINT_COUNT:     pc_reg = value[6:0];
			CFG_TARGET_CLUSTERS: tgt_reg = value[6:0];
			default:             cut_reg = value;
		endcase
	endtask

	task automatic setup(int n, int k, logic [31:0] cut);
		write_reg(CFG_POINT_COUNT, n);
		write_reg(CFG_TARGET_CLUSTERS, k);
		write_reg(CFG_DISTANCE_CUTOFF, cut);
	endtask

	// more: another item follows at once, so hold tvalid inside a burst
	task automatic send_word(logic [31:0] data, logic last, bit more);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_word(data, last);
		words_sent++;
		if (!(more && burst_left > 0)) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	function automatic logic [31:0] rand_dist(int style);
		case (style)
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 200) << 12;
			default: begin
				case ($urandom_range(0, 9))
					0: return 32'h0;
					1: return 32'hffff_ffff;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	// words = matrix size + extra (extra may be negative for a short load)
	task automatic send_matrix(int extra, int style);
		int n;
		int cnt;
		n = eff_points();
		cnt = n * (n - 1) / 2 + extra;
		if (cnt < 1) cnt = 1;
		for (int w = 0; w < cnt; w++) send_word(rand_dist(style), w == cnt - 1, w != cnt - 1);
	endtask

	task automatic drain();
		while (label_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// receiver: long hold-offs first, otherwise a ready pattern that is re-drawn at random, periodically
	int rcv_cyc = 0;
	always @(negedge clk) begin
		rcv_cyc <= rcv_cyc + 1;
		if (rcv_cyc % 64 == 0) ready_mode <= $urandom_range(0, 3);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				0, 1: m_tready <= 1'b1;
				2: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		label_item_t w;
		if (arst_n && m_tvalid && m_tready) begin
			labels_seen++;
			if (label_q.size() == 0) begin
				report("unexpected label item", m_tdata, 0);
			end else begin
				w = label_q.pop_front();
				if (m_tdata[5:0] != w.point) report("point_index", m_tdata[5:0], w.point);
				if (m_tdata[11:6] != w.label) report("cluster_label", m_tdata[11:6], w.label);
				if (m_tdata[18:12] != w.count) report("cluster_count", m_tdata[18:12], w.count);
				if (m_tdata[23:19] != 0) report("tdata pad bits", m_tdata[23:19], 0);
				if (m_tlast != w.last) report("last_result", m_tlast, w.last);
			end
		end
	end

	// full 8-point load with target and cutoff at reset: defines every entry read later
	task automatic test_reset_full();
		write_reg(CFG_POINT_COUNT, 8);
		send_matrix(0, 2);
		drain();
	endtask

	task automatic test_stop_rules();
		setup(6, 64, 32'hffff_ffff);
		send_matrix(0, 2);
		drain();
		setup(5, 0, 32'hffff_ffff);
		send_matrix(0, 0);
		drain();
		setup(4, 1, 32'h0);
		send_matrix(0, 0);
		drain();
		setup(6, 3, 32'h0000_8000);
		send_matrix(0, 1);
		drain();
	endtask

	task automatic test_point_range();
		setup(0, 1, 32'hffff_ffff);
		send_matrix(0, 2);
		drain();
		setup(1, 2, 32'hffff_ffff);
		send_matrix(0, 2);
		drain();
		// no merges at 64 points, so a short load reads nothing from the store
		setup(100, 64, 32'h0);
		send_matrix(-2010, 2);
		drain();
	endtask

	task automatic test_odd_loads();
		setup(3, 1, 32'hffff_ffff);
		send_matrix(3, 2);
		drain();
		setup(5, 2, 32'hffff_ffff);
		send_matrix(-6, 1);
		drain();
		// change the layout part way through a load
		setup(6, 2, 32'hffff_ffff);
		for (int w = 0; w < 4; w++) send_word(rand_dist(1), 1'b0, w < 3);
		repeat (60) @(posedge clk);
		write_reg(CFG_POINT_COUNT, 4);
		for (int w = 0; w < 3; w++) send_word(rand_dist(1), w == 2, w < 2);
		drain();
	endtask

	task automatic test_backpressure();
		setup(4, 2, 32'hffff_ffff);
		hold_cycles = 2500;
		send_matrix(0, 2);
		send_matrix(0, 0);
		send_matrix(0, 1);
		drain();
	endtask

	task automatic test_random();
		int n;
		int start_words;
		int start_labels;
		int extra;
		start_words = words_sent;
		start_labels = labels_seen;
		while (words_sent - start_words < 12 || labels_seen - start_labels < 10) begin
			n = $urandom_range(2, 8);
			case ($urandom_range(0, 3))
				0: setup(n, $urandom_range(1, n + 1), $urandom());
				1: setup(n, $urandom_range(0, 3), 32'h0000_1000 * $urandom_range(0, 100));
				default: setup(n, $urandom_range(1, n), 32'hffff_ffff);
			endcase
			case ($urandom_range(0, 7))
				0: extra = $urandom_range(1, 4);
				1: extra = -int'($urandom_range(1, 3));
				default: extra = 0;
			endcase
			send_matrix(extra, $urandom_range(0, 2));
			drain();
		end
	endtask

	initial begin
		for (int k = 0; k < DEPTH; k++) dist_mem[k] = '0;
		clear_batch();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_reset_full();
		test_stop_rules();
		test_point_range();
		test_odd_loads();
		test_backpressure();
		test_random();
		drain();
		$display("Covered %0d matrix batches from %0d distance items, %0d labels checked.",
			batches, words_sent, labels_seen);
		$display("Sizes 2 to 64, target/cutoff stops, short and long loads, output back-pressure.");
		if (errors == 0 && label_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Timeout with %0d labels outstanding", label_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
